FILE: design/cswd_pkg.sv
// Shared constants, codes and the result record for the camera stream deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package cswd_pkg;

    localparam int unsigned MAX_DIM      = 4096;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned DIM_W        = 13;
    localparam int unsigned POS_W        = 12;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MODE     = 2'd2;

    localparam logic [7:0] HDR_FIRST_0 = 8'h33;
    localparam logic [7:0] HDR_FIRST_1 = 8'hcc;
    localparam logic [7:0] HDR_LAST_0  = 8'h22;
    localparam logic [7:0] HDR_LAST_1  = 8'hdd;
    localparam logic [7:0] ROW_SYNC_0  = 8'h55;
    localparam logic [7:0] ROW_SYNC_1  = 8'haa;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

    typedef struct packed {
        logic [7:0]       pixel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             frame_end;
        logic             row_error;
    } t_res;

    // clamp a dimension to 1..MAX_DIM and return it minus one
    function automatic logic [POS_W-1:0] dim_minus_one(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] t;
        if (v == '0) begin
            t = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            t = DIM_W'(MAX_DIM);
        end else begin
            t = v;
        end
        t = t - DIM_W'(1);
        return t[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/cswd_front.sv
// Front end: configuration registers, sync search and counters; emits result records.
// Depends on cswd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cswd_front
    import cswd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_res                      o_push_res
);

    localparam logic [2:0] PH_HUNT       = 3'd0;
    localparam logic [2:0] PH_FRAME_DATA = 3'd1;
    localparam logic [2:0] PH_ROW_HI     = 3'd2;
    localparam logic [2:0] PH_ROW_LO     = 3'd3;
    localparam logic [2:0] PH_ROW_DATA   = 3'd4;

    logic [POS_W-1:0] r_wm1, n_wm1;
    logic [POS_W-1:0] r_hm1, n_hm1;
    logic             r_mode, n_mode;
    logic [2:0]       r_phase, n_phase;
    logic             r_seen, n_seen;
    logic [7:0]       r_row_hi, n_row_hi;
    logic [POS_W-1:0] r_row_num, n_row_num;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row_cnt, n_row_cnt;
    logic [7:0]       r_win [HEADER_BYTES];
    logic             win_shift, win_clear, restart, accept, hdr_hit;
    logic [15:0]      rx_num;
    logic             fe_frame, last_row;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_full;
    assign accept      = i_in_valid && !i_full;
    assign restart     = i_cfg_valid && (i_cfg_index == CFG_FRAME_WIDTH
                         || i_cfg_index == CFG_FRAME_HEIGHT || i_cfg_index == CFG_ROW_MODE);
    assign hdr_hit     = r_win[1] == HDR_FIRST_0 && r_win[2] == HDR_FIRST_1
                         && r_win[HEADER_BYTES-1] == HDR_LAST_0 && i_data_byte == HDR_LAST_1;
    assign rx_num      = {r_row_hi, i_data_byte};
    assign fe_frame    = r_row_cnt == r_hm1 && r_col == r_wm1;
    assign last_row    = r_col >= r_wm1;

    always_comb begin
        n_wm1      = r_wm1;
        n_hm1      = r_hm1;
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_seen     = r_seen;
        n_row_hi   = r_row_hi;
        n_row_num  = r_row_num;
        n_col      = r_col;
        n_row_cnt  = r_row_cnt;
        win_shift  = 1'b0;
        win_clear  = 1'b0;
        o_push     = 1'b0;
        o_push_res = '0;
        if (restart) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  n_wm1  = dim_minus_one(i_cfg_data);
                CFG_FRAME_HEIGHT: n_hm1  = dim_minus_one(i_cfg_data);
                default:          n_mode = i_cfg_data[0];
            endcase
            n_phase   = PH_HUNT;
            n_seen    = 1'b0;
            n_row_num = '0;
            n_col     = '0;
            n_row_cnt = '0;
            win_clear = 1'b1;
        end else if (accept) begin
            unique case (r_phase)
                PH_FRAME_DATA: begin
                    o_push     = 1'b1;
                    o_push_res = '{pixel: i_data_byte, row: r_row_cnt, column: r_col,
                                   frame_end: fe_frame, row_error: 1'b0};
                    if (fe_frame) begin
                        n_phase   = PH_HUNT;
                        n_col     = '0;
                        n_row_cnt = '0;
                    end else if (r_col == r_wm1) begin
                        n_col     = '0;
                        n_row_cnt = r_row_cnt + POS_W'(1);
                    end else begin
                        n_col = r_col + POS_W'(1);
                    end
                end
                PH_ROW_HI: begin
                    n_row_hi = i_data_byte;
                    n_phase  = PH_ROW_LO;
                end
                PH_ROW_LO: begin
                    if (rx_num > {4'd0, r_hm1}) begin
                        o_push     = 1'b1;
                        o_push_res = '{pixel: 8'd0, row: rx_num[POS_W-1:0], column: '0,
                                       frame_end: 1'b0, row_error: 1'b1};
                        n_phase    = PH_HUNT;
                    end else begin
                        n_row_num = rx_num[POS_W-1:0];
                        n_col     = '0;
                        n_phase   = PH_ROW_DATA;
                    end
                end
                PH_ROW_DATA: begin
                    o_push     = 1'b1;
                    o_push_res = '{pixel: i_data_byte, row: r_row_num, column: r_col,
                                   frame_end: last_row && r_row_num >= r_hm1,
                                   row_error: 1'b0};
                    if (last_row) begin
                        n_col   = '0;
                        n_phase = PH_HUNT;
                    end else begin
                        n_col = r_col + POS_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (r_mode) begin
                        if (!r_seen) begin
                            n_seen = i_data_byte == ROW_SYNC_0;
                        end else begin
                            n_seen = 1'b0;
                            if (i_data_byte == ROW_SYNC_1) begin
                                n_phase = PH_ROW_HI;
                            end
                        end
                    end else if (hdr_hit) begin
                        win_clear = 1'b1;
                        n_col     = '0;
                        n_row_cnt = '0;
                        n_phase   = PH_FRAME_DATA;
                    end else begin
                        win_shift = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1     <= dim_minus_one(RESET_WIDTH);
            r_hm1     <= dim_minus_one(RESET_HEIGHT);
            r_mode    <= 1'b0;
            r_phase   <= PH_HUNT;
            r_seen    <= 1'b0;
            r_row_num <= '0;
            r_col     <= '0;
            r_row_cnt <= '0;
        end else begin
            r_wm1     <= n_wm1;
            r_hm1     <= n_hm1;
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_seen    <= n_seen;
            r_row_num <= n_row_num;
            r_col     <= n_col;
            r_row_cnt <= n_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_hi <= n_row_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || win_clear) begin
            for (int i = 0; i < HEADER_BYTES; i++) begin
                r_win[i] <= '0;
            end
        end else if (win_shift) begin
            for (int i = 0; i < HEADER_BYTES - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[HEADER_BYTES-1] <= i_data_byte;
        end
    end

endmodule
`default_nettype wire

FILE: design/cswd_queue.sv
// Short result queue between the front end and the output stage.
// Depends on cswd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cswd_queue
    import cswd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_res i_push_res,
    input  wire logic i_pop,
    output t_res      o_pop_res,
    output logic      o_full,
    output logic      o_empty
);

    t_res              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full    = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty   = r_count == '0;
    assign o_pop_res = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_res;
        end
    end

endmodule
`default_nettype wire

FILE: design/cswd_back.sv
// Output stage: pops result records and holds them on the output channel.
// Depends on cswd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cswd_back
    import cswd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_res i_res,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_res      o_res
);

    logic r_valid;
    t_res r_res;

    assign o_pop       = !i_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

FILE: design/camera_stream_frame_deframer.sv
// Top level of the camera stream deframer: front end, result queue and output stage.
// Depends on cswd_pkg, cswd_front, cswd_queue and cswd_back.
//
// Takes one camera byte per cycle while the result queue is not full, and
// gives at most one pixel or row-error item per byte. The front end writes
// each result into the four-entry queue, from which the output stage pops it
// into its output register. Input stall rises only when the queue
// is full, so the input side runs freely while the output side takes an item
// every cycle. Configuration writes are always ready; a write to a known
// register abandons the frame or row in progress and restarts the search.
`timescale 1ns / 1ps
`default_nettype none
module camera_stream_frame_deframer
    import cswd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_pixel,
    output logic [POS_W-1:0]          o_row,
    output logic [POS_W-1:0]          o_column,
    output logic                      o_frame_end,
    output logic                      o_row_error
);

    logic push, pop, full, empty;
    t_res push_res, pop_res, out_res;

    cswd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_push_res  (push_res)
    );

    cswd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_res (push_res),
        .i_pop      (pop),
        .o_pop_res  (pop_res),
        .o_full     (full),
        .o_empty    (empty)
    );

    cswd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_res       (pop_res),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_pixel     = out_res.pixel;
    assign o_row       = out_res.row;
    assign o_column    = out_res.column;
    assign o_frame_end = out_res.frame_end;
    assign o_row_error = out_res.row_error;

endmodule
`default_nettype wire
